[sv/nat_pkg.sv]
`default_nettype none
package nat_pkg;
	typedef enum logic [2:0] {
		ACT_FWD = 3'd0,
		ACT_UNREACH = 3'd1,
		ACT_SILENT = 3'd2,
		ACT_FULL = 3'd3,
		ACT_TICK = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PORT,
		ST_COMMIT,
		ST_FREE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_TICK = 2'd2,
		OP_HELD = 2'd3
	} op_t;

	localparam logic [2:0] REG_EXT_ADDR = 3'd0;
	localparam logic [2:0] REG_IDLE_LIMIT = 3'd1;
	localparam logic [2:0] REG_RULE_EN = 3'd2;
	localparam logic [2:0] REG_RULE_PUB = 3'd3;
	localparam logic [2:0] REG_RULE_PADDR = 3'd4;
	localparam logic [2:0] REG_RULE_PPORT = 3'd5;

	typedef struct packed {
		op_t op;
		logic inbound;
		logic [47:0] remote;
		logic [47:0] priv;
		logic [15:0] pub;
		logic [15:0] idle_limit;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic [47:0] priv;
		logic [15:0] pub;
		logic has_free;
		logic held;
	} token_t;
endpackage
`default_nettype wire

[sv/nat_port_translation_table_top.sv]
// channel | dir | fields (low bit up)
// s_axis  | in  | tuser func,direction,is_tcp,fin,ack,rst; tdata saddr,daddr,sport,dport
// m_axis  | out | tuser action,removed_count; tdata new saddr,daddr,sport,dport
// cfg     | in  | cfg_index, cfg_data
// a packet reaches the output register after one walk over the cells, then commit; an
// outbound miss adds a search of the port bitmap before commit. a tick walks the cells,
// then does one port-held walk per removed entry. dropped packets skip the walk.
// reset clears valid bits and port bitmap at once, no clearing pass.
// input stalls until the result is taken by the output register.
`default_nettype none
module nat_port_translation_table_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int PORT_BASE = 12345,
	parameter int PORT_COUNT = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [95:0] s_axis_tdata, // source_address, dest_address, source_port, dest_port
	input wire logic [6:0] s_axis_tuser, // func, direction, is_tcp, fin_flag, ack_flag, rst_flag
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [95:0] m_axis_tdata, // new_source_address, new_dest_address, new_source_port, new_dest_port
	output logic [9:0] m_axis_tuser, // action, removed_count
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import nat_pkg::*;
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES+1);
	localparam int PW = $clog2(PORT_COUNT);

	logic [31:0] ext_addr_q, rule_paddr_q;
	logic [15:0] idle_q, rule_pub_q, rule_pport_q;
	logic rule_en_q;

	state_t st_q, st_n;
	logic [95:0] in_q;
	logic [6:0] usr_q;
	logic [PORT_COUNT-1:0] used_q;
	logic [PW-1:0] pidx_q;
	logic pfound_q;
	logic [IW-1:0] ridx_q;
	logic [TABLE_ENTRIES-1:0] rmask_q;
	cmd_t cmd;
	op_t op_q;
	logic start, wr, upd;
	logic [3:0] setf;
	logic busy;
	token_t res;
	logic [IW-1:0] hit_idx, free_idx;
	logic [TABLE_ENTRIES-1:0] rem_mask;
	logic [CW-1:0] rem_cnt;
	logic [6:0] rcount_q;
	logic [2:0] act_q;
	logic [95:0] o_q;
	logic [15:0] held_port_q;
	// shadow of each entry's public port, kept for the port release walk
	logic [15:0] portmem_q [TABLE_ENTRIES];

	logic [31:0] saddr, daddr;
	logic [15:0] sport, dport;
	logic inb;
	assign saddr = in_q[31:0];
	assign daddr = in_q[63:32];
	assign sport = in_q[79:64];
	assign dport = in_q[95:80];
	assign inb = usr_q[1];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_addr_q <= '0; idle_q <= 16'd60; rule_en_q <= 1'b0;
			rule_pub_q <= '0; rule_paddr_q <= '0; rule_pport_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EXT_ADDR: ext_addr_q <= cfg_data;
				REG_IDLE_LIMIT: idle_q <= cfg_data[15:0];
				REG_RULE_EN: rule_en_q <= cfg_data[0];
				REG_RULE_PUB: rule_pub_q <= cfg_data[15:0];
				REG_RULE_PADDR: rule_paddr_q <= cfg_data;
				REG_RULE_PPORT: rule_pport_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd.op = op_q;
		cmd.inbound = inb;
		cmd.remote = inb ? {saddr, sport} : {daddr, dport};
		cmd.priv = inb ? {rule_paddr_q, rule_pport_q} : {saddr, sport};
		cmd.pub = (op_q == OP_HELD) ? held_port_q
			: (inb ? (st_q == ST_COMMIT && !res.found ? rule_pub_q : dport)
			: 16'(PORT_BASE + int'(pidx_q)));
		cmd.idle_limit = idle_q;
	end

	nat_chain #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chain (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.wr_idx(free_idx), .wr(wr), .upd(upd), .setf(setf),
		.busy(busy), .result(res), .hit_idx(hit_idx), .free_idx(free_idx),
		.removed_mask(rem_mask), .removed_cnt(rem_cnt)
	);

	always_comb begin
		setf = 4'd0;
		if (inb) setf = {usr_q[5], usr_q[4], 2'b00};
		else setf = {2'b00, usr_q[5], usr_q[4]};
		if (usr_q[6]) setf = 4'hF;
	end

	logic in_range;
	assign in_range = {16'd0, held_port_q} >= 32'(PORT_BASE) &&
		{16'd0, held_port_q} < 32'(PORT_BASE + PORT_COUNT);
	logic [15:0] pub_off;
	assign pub_off = rule_pub_q - 16'(PORT_BASE);
	logic pub_in;
	assign pub_in = {16'd0, rule_pub_q} >= 32'(PORT_BASE) &&
		{16'd0, rule_pub_q} < 32'(PORT_BASE + PORT_COUNT);

	assign s_axis_tready = st_q == ST_IDLE;
	assign start = (st_q == ST_IDLE && s_axis_tvalid && s_axis_tuser[0] == 1'b0 &&
		s_axis_tuser[2:1] <= 2'd1 && s_axis_tuser[3]) ||
		(st_q == ST_IDLE && s_axis_tvalid && s_axis_tuser[0]) ||
		(st_q == ST_FREE && !busy && op_q != OP_HELD && rmask_q != '0) ||
		(st_q == ST_FREE && !busy && op_q == OP_HELD && ridx_q != IW'(TABLE_ENTRIES-1) &&
			(rmask_q >> (ridx_q + 1'b1)) != '0);

	logic commit_ok;
	assign commit_ok = res.found || (res.has_free && (inb || pfound_q));
	assign wr = st_q == ST_COMMIT && !res.found && commit_ok &&
		!(inb && !(rule_en_q && daddr == ext_addr_q && dport == rule_pub_q));
	assign upd = st_q == ST_COMMIT && res.found;

	always_comb begin
		st_n = st_q;
		case (st_q)
			ST_IDLE: if (s_axis_tvalid) begin
				if (s_axis_tuser[0] || (s_axis_tuser[2:1] <= 2'd1 && s_axis_tuser[3]))
					st_n = ST_SCAN;
				else st_n = ST_OUT;
			end
			ST_SCAN: if (!busy) begin
				if (op_q == OP_TICK) st_n = ST_FREE;
				else if (!res.found && !inb) st_n = ST_PORT;
				else st_n = ST_COMMIT;
			end
			ST_PORT: if (!used_q[pidx_q] || pidx_q == PW'(PORT_COUNT-1)) st_n = ST_COMMIT;
			ST_COMMIT: st_n = ST_OUT;
			ST_FREE: if (!busy && !start) st_n = ST_OUT;
			ST_OUT: if (!m_axis_tvalid) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			used_q <= '0;
			m_axis_tvalid <= 1'b0;
			op_q <= OP_NONE;
		end else begin
			st_q <= st_n;
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: if (s_axis_tvalid) begin
					in_q <= s_axis_tdata;
					usr_q <= s_axis_tuser;
					o_q <= '0;
					rcount_q <= '0;
					if (s_axis_tuser[0]) begin
						op_q <= OP_TICK;
					end else if (s_axis_tuser[2:1] > 2'd1) begin
						act_q <= ACT_UNREACH;
					end else if (!s_axis_tuser[3]) begin
						act_q <= ACT_SILENT;
					end else begin
						op_q <= OP_LOOKUP;
					end
				end
				ST_SCAN: if (!busy) begin
					if (op_q == OP_TICK) begin
						rmask_q <= rem_mask;
						rcount_q <= 7'(rem_cnt);
						ridx_q <= '0;
					end else if (!res.found && !inb) begin
						pidx_q <= '0; pfound_q <= 1'b0;
					end
				end
				ST_PORT: begin
					if (!used_q[pidx_q]) pfound_q <= 1'b1;
					else if (pidx_q != PW'(PORT_COUNT-1)) pidx_q <= pidx_q + 1'b1;
				end
				ST_COMMIT: begin
					if (inb && !res.found && !(rule_en_q && daddr == ext_addr_q &&
						dport == rule_pub_q)) act_q <= ACT_UNREACH;
					else if (!commit_ok) act_q <= ACT_FULL;
					else begin
						act_q <= ACT_FWD;
						if (!res.found) begin
							if (inb && pub_in) used_q[pub_off[PW-1:0]] <= 1'b1;
							if (!inb) used_q[pidx_q] <= 1'b1;
						end
						if (inb) o_q <= {(res.found ? res.priv[15:0] : rule_pport_q), sport,
							(res.found ? res.priv[47:16] : rule_paddr_q), saddr};
						else o_q <= {dport, (res.found ? res.pub :
							16'(PORT_BASE + int'(pidx_q))), daddr, ext_addr_q};
					end
				end
				ST_FREE: if (!busy) begin
					// one held-port walk per removed entry
					if (op_q == OP_HELD) begin
						if (!res.held && in_range)
							used_q[PW'(held_port_q - 16'(PORT_BASE))] <= 1'b0;
						rmask_q[ridx_q] <= 1'b0;
					end
					if (start) begin
						logic [IW-1:0] k;
						k = '0;
						for (int j = TABLE_ENTRIES-1; j >= 0; j--)
							if (rmask_q[j] && !(op_q == OP_HELD && IW'(j) == ridx_q)) k = IW'(j);
						ridx_q <= k;
						held_port_q <= portmem_q[k];
						op_q <= OP_HELD;
					end else begin
						act_q <= ACT_TICK; op_q <= OP_NONE;
					end
				end
				ST_OUT: if (!m_axis_tvalid) begin
					m_axis_tvalid <= 1'b1;
					m_axis_tdata <= o_q;
					m_axis_tuser <= {rcount_q, act_q};
					op_q <= OP_NONE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) portmem_q[free_idx] <= cmd.pub;
	end
endmodule
`default_nettype wire

[sv/nat_cell.sv]
`default_nettype none
module nat_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic act,
	input wire nat_pkg::cmd_t cmd,
	input wire nat_pkg::token_t tok_in,
	output nat_pkg::token_t tok_out,
	input wire logic wr,
	input wire logic upd,
	input wire logic [3:0] setf,
	output logic removed
);
	import nat_pkg::*;
	logic valid_q;
	logic [47:0] remote_q, priv_q;
	logic [15:0] pub_q, age_q, age_n;
	logic [3:0] flags_q;
	logic hit, kill;

	always_comb begin
		hit = valid_q && remote_q == cmd.remote &&
			(cmd.inbound ? pub_q == cmd.pub : priv_q == cmd.priv);
		age_n = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
		kill = valid_q && (flags_q == 4'hF || age_n >= cmd.idle_limit);
		tok_out = tok_in;
		removed = 1'b0;
		if (act) begin
			case (cmd.op)
				OP_LOOKUP: begin
					if (!tok_in.found && hit) begin
						tok_out.found = 1'b1;
						tok_out.priv = priv_q;
						tok_out.pub = pub_q;
					end
					if (!valid_q) tok_out.has_free = 1'b1;
				end
				OP_TICK: removed = kill;
				OP_HELD: if (valid_q && pub_q == cmd.pub) tok_out.held = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (wr) valid_q <= 1'b1;
		else if (act && cmd.op == OP_TICK && kill) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			remote_q <= cmd.remote;
			priv_q <= cmd.priv;
			pub_q <= cmd.pub;
			age_q <= 16'd0;
			flags_q <= setf;
		end else if (upd) begin
			age_q <= 16'd0;
			flags_q <= flags_q | setf;
		end else if (act && cmd.op == OP_TICK && valid_q) begin
			age_q <= age_n;
		end
	end
endmodule
`default_nettype wire

[sv/nat_chain.sv]
`default_nettype none
module nat_chain #(
	parameter int TABLE_ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire nat_pkg::cmd_t cmd,
	input wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
	input wire logic wr,
	input wire logic upd,
	input wire logic [3:0] setf,
	output logic busy,
	output nat_pkg::token_t result,
	output logic [$clog2(TABLE_ENTRIES)-1:0] hit_idx,
	output logic [$clog2(TABLE_ENTRIES)-1:0] free_idx,
	output logic [TABLE_ENTRIES-1:0] removed_mask,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] removed_cnt
);
	import nat_pkg::*;
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES+1);
	// token walks one cell per cycle
	token_t tok_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [TABLE_ENTRIES-1:0] rem_q;
	token_t tok [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] rem;
	token_t cur;

	genvar g;
	for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		nat_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.act(busy && pos_q == IW'(g)),
			.cmd(cmd), .tok_in(tok_q), .tok_out(tok[g]),
			.wr(wr && wr_idx == IW'(g)),
			.upd(upd && hit_idx == IW'(g)),
			.setf(setf), .removed(rem[g])
		);
	end

	assign cur = tok[pos_q];
	assign result = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			pos_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			pos_q <= '0;
		end else if (busy) begin
			if (pos_q == IW'(TABLE_ENTRIES-1)) busy <= 1'b0;
			else pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tok_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
		end else if (busy) begin
			tok_q <= cur;
			if (cur.found && !tok_q.found) hit_idx <= pos_q;
			if (cur.has_free && !tok_q.has_free) free_idx <= pos_q;
			if (rem[pos_q]) begin
				cnt_q <= cnt_q + 1'b1;
				rem_q[pos_q] <= 1'b1;
			end
		end
	end
	assign removed_mask = rem_q;
	assign removed_cnt = cnt_q;
endmodule
`default_nettype wire

[sv/nat_checker.sv]
`default_nettype none
module nat_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [9:0] m_axis_tuser
);
	import nat_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
		else $error("result dropped");
	a_act: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:0] <= ACT_TICK)
		else $error("bad action");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] != ACT_TICK |-> m_axis_tuser[9:3] == 7'd0)
		else $error("count on packet");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted during work");
endmodule
bind nat_port_translation_table_top nat_props u_chk (.*);
`default_nettype wire

[tb/sv/nat_checker.sv]
`default_nettype none
module nat_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [95:0] s_axis_tdata,
	input wire logic [6:0] s_axis_tuser,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	input wire logic [9:0] m_axis_tuser,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output int errors,
	output int pending,
	output int n_fwd,
	output int n_full,
	output int n_removed
);
	timeunit 1ns;
	timeprecision 1ps;
	import nat_pkg::*;

	localparam int ENTRIES = 64;
	localparam int PBASE = 12345;
	localparam int PCOUNT = 64;

	typedef struct packed {
		action_t act;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [6:0] removed;
	} xlat_t;

	logic [31:0] ext_addr;
	logic [15:0] idle_lim;
	logic rule_en;
	logic [15:0] rule_pub;
	logic [31:0] rule_paddr;
	logic [15:0] rule_pport;

	logic map_valid [ENTRIES];
	logic [47:0] map_remote [ENTRIES];
	logic [47:0] map_priv [ENTRIES];
	logic [15:0] map_pub [ENTRIES];
	logic [15:0] map_age [ENTRIES];
	logic [3:0] map_close [ENTRIES];
	logic port_busy [PCOUNT];

	xlat_t expected_q[$];

	function automatic bit in_pool(logic [15:0] p);
		return int'(p) >= PBASE && int'(p) < PBASE + PCOUNT;
	endfunction

	function automatic int first_free_slot();
		for (int i = 0; i < ENTRIES; i++)
			if (!map_valid[i])
				return i;
		return -1;
	endfunction

	function automatic xlat_t age_table();
		xlat_t r;
		logic [15:0] gone [ENTRIES];
		int cnt;
		bit held;
		r = '0;
		cnt = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (map_valid[i]) begin
				if (map_age[i] != 16'hffff)
					map_age[i]++;
				if (map_close[i] == 4'hf || map_age[i] >= idle_lim) begin
					map_valid[i] = 1'b0;
					gone[cnt] = map_pub[i];
					cnt++;
				end
			end
		end
		for (int k = 0; k < cnt; k++) begin
			held = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (map_valid[i] && map_pub[i] == gone[k])
					held = 1;
			if (in_pool(gone[k]) && !held)
				port_busy[int'(gone[k]) - PBASE] = 1'b0;
		end
		r.act = ACT_TICK;
		r.removed = 7'(cnt);
		return r;
	endfunction

	function automatic xlat_t translate(logic [6:0] u, logic [95:0] d);
		xlat_t r;
		logic [1:0] dir;
		logic [31:0] sa, da;
		logic [15:0] sp, dp;
		logic [47:0] remote, priv;
		logic [3:0] setf;
		int e, p;
		r = '0;
		dir = u[2:1];
		sa = d[31:0];
		da = d[63:32];
		sp = d[79:64];
		dp = d[95:80];
		setf = '0;
		e = -1;
		p = -1;
		if (u[0])
			return age_table();
		if (dir > 2'd1) begin
			r.act = ACT_UNREACH;
			return r;
		end
		if (!u[3]) begin
			r.act = ACT_SILENT;
			return r;
		end
		if (dir == 2'd0) begin
			remote = {da, dp};
			priv = {sa, sp};
			for (int i = 0; i < ENTRIES && e < 0; i++)
				if (map_valid[i] && map_remote[i] == remote && map_priv[i] == priv)
					e = i;
			if (e < 0) begin
				e = first_free_slot();
				for (int i = 0; i < PCOUNT && p < 0; i++)
					if (!port_busy[i])
						p = i;
				if (e < 0 || p < 0) begin
					r.act = ACT_FULL;
					return r;
				end
				port_busy[p] = 1'b1;
				map_valid[e] = 1'b1;
				map_remote[e] = remote;
				map_priv[e] = priv;
				map_pub[e] = 16'(PBASE + p);
				map_close[e] = '0;
			end
			setf = {2'b00, u[5], u[4]};
		end else begin
			remote = {sa, sp};
			for (int i = 0; i < ENTRIES && e < 0; i++)
				if (map_valid[i] && map_remote[i] == remote && map_pub[i] == dp)
					e = i;
			if (e < 0) begin
				if (!rule_en || da != ext_addr || dp != rule_pub) begin
					r.act = ACT_UNREACH;
					return r;
				end
				e = first_free_slot();
				if (e < 0) begin
					r.act = ACT_FULL;
					return r;
				end
				map_valid[e] = 1'b1;
				map_remote[e] = remote;
				map_priv[e] = {rule_paddr, rule_pport};
				map_pub[e] = rule_pub;
				map_close[e] = '0;
				if (in_pool(rule_pub))
					port_busy[int'(rule_pub) - PBASE] = 1'b1;
			end
			setf = {u[5], u[4], 2'b00};
		end
		if (u[6])
			setf = 4'hf;
		map_close[e] = map_close[e] | setf;
		map_age[e] = '0;
		r.act = ACT_FWD;
		if (dir == 2'd0) begin
			r.saddr = ext_addr;
			r.daddr = da;
			r.sport = map_pub[e];
			r.dport = dp;
		end else begin
			r.saddr = sa;
			r.daddr = map_priv[e][47:16];
			r.sport = sp;
			r.dport = map_priv[e][15:0];
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		xlat_t want;
		int bad;
		if (!arst_n) begin
			ext_addr <= '0;
			idle_lim <= 16'd60;
			rule_en <= 1'b0;
			rule_pub <= '0;
			rule_paddr <= '0;
			rule_pport <= '0;
			for (int i = 0; i < ENTRIES; i++)
				map_valid[i] = 1'b0;
			for (int i = 0; i < PCOUNT; i++)
				port_busy[i] = 1'b0;
			errors <= 0;
			n_fwd <= 0;
			n_full <= 0;
			n_removed <= 0;
		end else begin
			bad = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result action %0d", m_axis_tuser[2:0]);
					bad++;
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tuser[2:0] != want.act) begin
						$error("action exp %0d got %0d", want.act, m_axis_tuser[2:0]);
						bad++;
					end
					if (m_axis_tuser[9:3] != want.removed) begin
						$error("removed_count exp %0d got %0d", want.removed, m_axis_tuser[9:3]);
						bad++;
					end
					if (m_axis_tdata[31:0] != want.saddr) begin
						$error("new_source_address exp %h got %h", want.saddr, m_axis_tdata[31:0]);
						bad++;
					end
					if (m_axis_tdata[63:32] != want.daddr) begin
						$error("new_dest_address exp %h got %h", want.daddr, m_axis_tdata[63:32]);
						bad++;
					end
					if (m_axis_tdata[79:64] != want.sport) begin
						$error("new_source_port exp %0d got %0d", want.sport, m_axis_tdata[79:64]);
						bad++;
					end
					if (m_axis_tdata[95:80] != want.dport) begin
						$error("new_dest_port exp %0d got %0d", want.dport, m_axis_tdata[95:80]);
						bad++;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
			if (s_axis_tvalid && s_axis_tready) begin
				want = translate(s_axis_tuser, s_axis_tdata);
				expected_q.push_back(want);
				if (want.act == ACT_FWD)
					n_fwd <= n_fwd + 1;
				if (want.act == ACT_FULL)
					n_full <= n_full + 1;
				n_removed <= n_removed + int'(want.removed);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EXT_ADDR: ext_addr <= cfg_data;
					REG_IDLE_LIMIT: idle_lim <= cfg_data[15:0];
					REG_RULE_EN: rule_en <= cfg_data[0];
					REG_RULE_PUB: rule_pub <= cfg_data[15:0];
					REG_RULE_PADDR: rule_paddr <= cfg_data;
					REG_RULE_PPORT: rule_pport <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nat_pkg::*;

	localparam int PBASE = 12345;
	localparam int IDLE_LIMIT_CYCLES = 20000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [6:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic [9:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	int errors, pending, n_fwd, n_full, n_removed;
	int n_requests;
	bit hold_go;
	bit fill_mode;
	int fill_port;

	logic [31:0] ext_now;
	logic [15:0] rule_pub_now;
	logic [31:0] priv_addr [8];
	logic [15:0] priv_port [4];
	logic [31:0] remote_addr [4];
	logic [15:0] peer_port [2];

	nat_port_translation_table_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	nat_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.n_fwd(n_fwd),
		.n_full(n_full),
		.n_removed(n_removed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		int stall;
		int r;
		bit held_done;
		stall = 0;
		held_done = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !held_done) begin
				held_done = 1;
				stall = 400;
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready = 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					m_axis_tready = 1'b1;
				end else begin
					m_axis_tready = 1'b0;
					stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
				end
			end
		end
	end

	// watchdog
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT_CYCLES) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_request(input logic [6:0] u, input logic [95:0] d);
		int r;
		int gap;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = u;
		s_axis_tdata = d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_requests++;
		r = $urandom_range(99);
		gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_packet(input logic [1:0] dir, input logic tcp, input logic [31:0] sa,
	                           input logic [31:0] da, input logic [15:0] sp, input logic [15:0] dp,
	                           input logic fin, input logic ack, input logic rst);
		send_request({rst, ack, fin, tcp, dir, 1'b0}, {dp, sp, da, sa});
	endtask

	task automatic send_tick();
		send_request(7'b0000001, {$urandom(), $urandom(), $urandom()});
	endtask

	task automatic send_random();
		int r;
		logic fin, ack, rst;
		r = $urandom_range(99);
		fin = ($urandom_range(99) < 25);
		ack = ($urandom_range(99) < 40);
		rst = ($urandom_range(99) < 5);
		if (r < 8) begin
			send_tick();
		end else if (r < 12) begin
			send_packet(2'($urandom_range(2, 3)), 1'($urandom()), $urandom(), $urandom(),
			            16'($urandom()), 16'($urandom()), fin, ack, rst);
		end else if (r < 16) begin
			send_packet(2'($urandom_range(0, 1)), 1'b0, $urandom(), $urandom(),
			            16'($urandom()), 16'($urandom()), fin, ack, rst);
		end else if (r < 60) begin
			if (fill_mode) begin
				fill_port++;
				send_packet(2'd0, 1'b1, priv_addr[$urandom_range(0, 7)],
				            remote_addr[$urandom_range(0, 3)], 16'(fill_port),
				            peer_port[$urandom_range(0, 1)], fin, ack, 1'b0);
			end else begin
				send_packet(2'd0, 1'b1, priv_addr[$urandom_range(0, 7)],
				            remote_addr[$urandom_range(0, 3)], priv_port[$urandom_range(0, 3)],
				            peer_port[$urandom_range(0, 1)], fin, ack, rst);
			end
		end else if (r < 85) begin
			send_packet(2'd1, 1'b1, remote_addr[$urandom_range(0, 3)], ext_now,
			            peer_port[$urandom_range(0, 1)], 16'(PBASE + $urandom_range(0, 9)),
			            fin, ack, rst);
		end else if (r < 95) begin
			send_packet(2'd1, 1'b1, remote_addr[$urandom_range(0, 3)], ext_now,
			            16'($urandom()), rule_pub_now, fin, ack, rst);
		end else begin
			send_request({3'($urandom()), 1'b1, 2'($urandom_range(0, 1)), 1'b0},
			             {$urandom(), $urandom(), $urandom()});
		end
	endtask

	task automatic set_all(input logic [31:0] ext, input logic [15:0] lim, input logic en,
	                       input logic [15:0] pub, input logic [31:0] paddr, input logic [15:0] pport);
		write_reg(REG_EXT_ADDR, ext);
		write_reg(REG_IDLE_LIMIT, {16'h0, lim});
		write_reg(REG_RULE_EN, {31'h0, en});
		write_reg(REG_RULE_PUB, {16'h0, pub});
		write_reg(REG_RULE_PADDR, paddr);
		write_reg(REG_RULE_PPORT, {16'h0, pport});
		ext_now = ext;
		rule_pub_now = pub;
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_go = 0;
		fill_mode = 0;
		fill_port = 2000;
		n_requests = 0;
		for (int i = 0; i < 8; i++)
			priv_addr[i] = $urandom();
		priv_addr[0] = '0;
		priv_addr[1] = '1;
		for (int i = 0; i < 4; i++)
			priv_port[i] = 16'($urandom());
		priv_port[0] = 16'h0000;
		priv_port[1] = 16'hffff;
		for (int i = 0; i < 4; i++)
			remote_addr[i] = $urandom();
		remote_addr[0] = '1;
		peer_port[0] = 16'd80;
		peer_port[1] = 16'($urandom());
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_all(32'hc0a80001, 16'd3, 1'b1, 16'(PBASE + 5), 32'h0a000009, 16'd80);
		// one flow through its close handshake
		send_packet(2'd0, 1'b1, 32'h0a000001, 32'h08080808, 16'd1000, 16'd80, 0, 1, 0);
		send_packet(2'd0, 1'b1, 32'h0a000001, 32'h08080808, 16'd1000, 16'd80, 0, 0, 0);
		send_packet(2'd1, 1'b1, 32'h08080808, 32'hc0a80001, 16'd80, 16'(PBASE), 1, 0, 0);
		send_packet(2'd0, 1'b1, 32'h0a000001, 32'h08080808, 16'd1000, 16'd80, 1, 0, 0);
		send_packet(2'd1, 1'b1, 32'h08080808, 32'hc0a80001, 16'd80, 16'(PBASE), 0, 1, 0);
		send_packet(2'd1, 1'b1, 32'h08080808, 32'hc0a80001, 16'd80, 16'd999, 0, 0, 0);
		send_packet(2'd1, 1'b1, 32'h01020304, 32'hc0a80001, 16'd5555, 16'(PBASE + 5), 0, 0, 0);
		send_packet(2'd1, 1'b1, 32'h01020304, 32'hc0a80002, 16'd5555, 16'(PBASE + 5), 0, 0, 0);
		send_packet(2'd2, 1'b1, 32'h1, 32'h2, 16'd3, 16'd4, 0, 0, 0);
		send_packet(2'd3, 1'b0, 32'h1, 32'h2, 16'd3, 16'd4, 1, 1, 1);
		send_packet(2'd0, 1'b0, 32'h1, 32'h2, 16'd3, 16'd4, 0, 0, 0);
		send_packet(2'd1, 1'b0, 32'h1, 32'h2, 16'd3, 16'd4, 0, 0, 0);
		send_packet(2'd0, 1'b1, 32'hffffffff, 32'h0, 16'hffff, 16'h0, 1, 1, 1);
		send_packet(2'd0, 1'b1, 32'h0, 32'hffffffff, 16'h0, 16'hffff, 0, 0, 0);
		send_packet(2'd1, 1'b1, 32'hffffffff, 32'h0, 16'hffff, 16'(PBASE + 1), 1, 1, 0);
		send_tick();
		send_tick();
		send_tick();
		send_tick();
		for (int n = 0; n < 250; n++) begin
			if (n == 100)
				hold_go = 1;
			send_random();
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_drained();

		// long limit: the table and the port pool fill up
		set_all(32'hffffffff, 16'hffff, 1'b1, 16'hffff, 32'hffffffff, 16'hffff);
		fill_mode = 1;
		for (int n = 0; n < 250; n++)
			send_random();
		fill_mode = 0;
		for (int n = 0; n < 3; n++)
			send_tick();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_drained();

		// shortest limit, rule off
		set_all(32'h00000000, 16'd1, 1'b0, 16'h0000, 32'h00000000, 16'h0000);
		for (int n = 0; n < 250; n++)
			send_random();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);

		$display("covered %0d requests over three register settings", n_requests);
		$display("%0d forwarded, %0d table-full, %0d mappings aged out", n_fwd, n_full, n_removed);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
sv/nat_pkg.sv
sv/nat_cell.sv
sv/nat_chain.sv
sv/nat_port_translation_table_top.sv
sv/nat_checker.sv
tb/sv/nat_checker.sv
tb/sv/tb_top.sv
